// ----- src/keypad_lock_controller_defines.svh -----
// Assertion macros shared by the keypad lock controller RTL.
// Each macro expects signals named clk and rst_n in the including scope.
// No other dependencies.
`ifndef KEYPAD_LOCK_CONTROLLER_DEFINES_SVH
`define KEYPAD_LOCK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/klc_pkg.sv -----
// Shared types and codes for the keypad lock controller.
// Holds the input and result word structs and the fixed codes.
// No dependencies.
package klc_pkg;

    localparam int SLOTS = 8;

    typedef logic [3:0] digit_t;

    localparam digit_t BLANK_DIGIT = 4'd10;
    localparam logic [6:0] LEVEL_MAX = 7'd84;
    localparam logic [9:0] IDLE_SCAN_MAX = 10'd1023;
    localparam logic [7:0] OPEN_SEC_MAX = 8'd255;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_SCAN   = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;
    localparam logic [1:0] KIND_REMOTE = 2'd3;

    localparam logic [3:0] KEY_DELETE  = 4'd10;
    localparam logic [3:0] KEY_CLEAR   = 4'd11;
    localparam logic [3:0] KEY_CONFIRM = 4'd12;
    localparam logic [3:0] KEY_CLOSE   = 4'd13;

    localparam logic [1:0] DOOR_CLOSED = 2'd0;
    localparam logic [1:0] DOOR_OPEN   = 2'd1;
    localparam logic [1:0] DOOR_ALARM  = 2'd2;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_UNLOCKED   = 3'd1;
    localparam logic [2:0] EV_CLOSED     = 3'd2;
    localparam logic [2:0] EV_WRONG_CODE = 3'd3;
    localparam logic [2:0] EV_LEFT_OPEN  = 3'd4;

    localparam logic [1:0] REG_PASS_CODE    = 2'd0;
    localparam logic [1:0] REG_OPEN_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_TRIES        = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] key_index;
    } evt_word_t;

    typedef struct packed {
        logic [1:0] door_state;
        logic       display_on;
        logic [2:0] entered_count;
        digit_t     digit_one;
        digit_t     digit_two;
        digit_t     digit_three;
        digit_t     digit_four;
        digit_t     digit_five;
        digit_t     digit_six;
        logic       lamp;
        logic       locked_out;
        logic [2:0] event_res;
    } stat_word_t;

endpackage

// ----- src/keypad_lock_controller.sv -----
// Keypad combination lock controller: top level with all lock state.
// Depends on klc_pkg and on keypad_lock_controller_defines.svh.
// Single module; no memories.
//
//   Channel   Direction  Handshake               Word
//   evt       in         evt_valid / evt_ready   klc_pkg::evt_word_t (kind, key_index)
//   stat      out        stat_valid / stat_ready klc_pkg::stat_word_t (door, display, digits)
//   apb       in/out     psel, penable, pwrite   four registers at byte addresses 0, 4, 8, 12
//
// Every accepted word produces exactly one result word, in the cycle after acceptance.
// The lock state and the result register are updated at the same edge, so one word
// can be accepted every cycle: the feedback path through the state registers is one
// pass of small compare and increment logic. evt_ready is low only while a result is
// held and stat_ready is low. Reset (rst_n, asynchronous) clears all lock state to the
// closed, idle, blank display with the lamp on, and loads the register defaults.
`include "keypad_lock_controller_defines.svh"

module keypad_lock_controller #(
    parameter int CODE_DIGITS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_valid,
    output logic                   evt_ready,
    input  klc_pkg::evt_word_t     evt,
    output logic                   stat_valid,
    input  logic                   stat_ready,
    output klc_pkg::stat_word_t    stat,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import klc_pkg::*;

    // Entry counter must hold CODE_DIGITS itself; slot index covers all slots.
    localparam int CNT_W = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W = $clog2(SLOTS);

    // Splits a lockout count of at most 255 into three decimal digits.
    // Tens come from a multiply by the reciprocal of ten, exact below 1029.
    function automatic logic [11:0] to_bcd3(input logic [7:0] value);
        logic [3:0]  hund;
        logic [7:0]  rest;
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [7:0]  units;
        if (value >= 8'd200)
        begin
            hund = 4'd2;
            rest = value - 8'd200;
        end
        else if (value >= 8'd100)
        begin
            hund = 4'd1;
            rest = value - 8'd100;
        end
        else
        begin
            hund = 4'd0;
            rest = value;
        end
        prod  = 16'(rest) * 16'd205;
        tens  = prod[14:11];
        units = rest - 8'(tens) * 8'd10;
        return {hund, tens, units[3:0]};
    endfunction

    // Configuration registers.
    logic [23:0] pass_code_reg;
    logic [7:0]  open_timeout_reg;
    logic [9:0]  idle_timeout_reg;
    logic [1:0]  tries_reg;

    // Lock state.
    logic [1:0]       door_mode_reg,      door_mode_next;
    logic             display_active_reg, display_active_next;
    logic [CNT_W-1:0] entry_count_reg,    entry_count_next;
    digit_t           digits_reg [SLOTS];
    digit_t           digits_next [SLOTS];
    logic [1:0]       fail_count_reg,     fail_count_next;
    logic [6:0]       lockout_level_reg,  lockout_level_next;
    logic [7:0]       lockout_left_reg,   lockout_left_next;
    logic             lockout_active_reg, lockout_active_next;
    logic [7:0]       open_seconds_reg,   open_seconds_next;
    logic [9:0]       idle_scans_reg,     idle_scans_next;
    logic             lamp_level_reg,     lamp_level_next;

    // Result register.
    logic       stat_valid_reg, stat_valid_next;
    stat_word_t stat_reg,       stat_next;

    logic       accept;
    logic       cfg_write;
    logic [2:0] event_code;

    // Combinational helpers for the confirm and lockout paths.
    logic [31:0]      code_ext;
    logic             code_match;
    logic [1:0]       tries_eff;
    logic [1:0]       fail_inc;
    logic [6:0]       level_inc;
    logic [8:0]       left_product;
    logic [7:0]       left_dec;
    logic [11:0]      left_bcd;
    logic [9:0]       scans_inc;
    logic [7:0]       seconds_inc;
    logic [IDX_W-1:0] put_idx;
    logic [IDX_W-1:0] del_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // A result waiting in the output register blocks only if it is not taken now.
    assign evt_ready  = !stat_valid_reg || stat_ready;
    assign accept     = evt_valid && evt_ready;
    assign stat_valid = stat_valid_reg;
    assign stat       = stat_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PASS_CODE:    prdata = {8'd0, pass_code_reg};
            REG_OPEN_TIMEOUT: prdata = {24'd0, open_timeout_reg};
            REG_IDLE_TIMEOUT: prdata = {22'd0, idle_timeout_reg};
            REG_TRIES:        prdata = {30'd0, tries_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_code_reg    <= 24'h123456;
            open_timeout_reg <= 8'd20;
            idle_timeout_reg <= 10'd150;
            tries_reg        <= 2'd3;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PASS_CODE:    pass_code_reg    <= pwdata[23:0];
                REG_OPEN_TIMEOUT: open_timeout_reg <= pwdata[7:0];
                REG_IDLE_TIMEOUT: idle_timeout_reg <= pwdata[9:0];
                REG_TRIES:        tries_reg        <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    // Code check: slot i holds the digit in nibble CODE_DIGITS-1-i of the packed
    // code; nibbles above the 24-bit register read as zero.
    assign code_ext = {8'd0, pass_code_reg};

    always_comb
    begin
        code_match = (entry_count_reg >= CNT_W'(CODE_DIGITS));
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (digits_reg[i] != code_ext[4 * (CODE_DIGITS - 1 - i) +: 4])
            begin
                code_match = 1'b0;
            end
        end
    end

    // A tries setting of zero behaves as one. The lockout length is
    // tries * level + 1, at most 3 * 84 + 1 = 253.
    assign tries_eff    = (tries_reg == 2'd0) ? 2'd1 : tries_reg;
    assign fail_inc     = fail_count_reg + 2'd1;
    assign level_inc    = (lockout_level_reg < LEVEL_MAX) ? lockout_level_reg + 7'd1
                                                          : lockout_level_reg;
    assign left_product = 9'(tries_eff) * 9'(level_inc) + 9'd1;
    assign left_dec     = (lockout_left_reg != 8'd0) ? lockout_left_reg - 8'd1
                                                     : lockout_left_reg;
    assign left_bcd     = to_bcd3(left_dec);
    assign scans_inc    = (idle_scans_reg < IDLE_SCAN_MAX) ? idle_scans_reg + 10'd1
                                                           : idle_scans_reg;
    assign seconds_inc  = (open_seconds_reg < OPEN_SEC_MAX) ? open_seconds_reg + 8'd1
                                                            : open_seconds_reg;
    assign put_idx      = IDX_W'(entry_count_reg);
    assign del_idx      = IDX_W'(entry_count_reg - CNT_W'(1));

    // Next lock state for the word at the input.
    always_comb
    begin
        door_mode_next      = door_mode_reg;
        display_active_next = display_active_reg;
        entry_count_next    = entry_count_reg;
        digits_next         = digits_reg;
        fail_count_next     = fail_count_reg;
        lockout_level_next  = lockout_level_reg;
        lockout_left_next   = lockout_left_reg;
        lockout_active_next = lockout_active_reg;
        open_seconds_next   = open_seconds_reg;
        idle_scans_next     = idle_scans_reg;
        lamp_level_next     = lamp_level_reg;
        event_code          = EV_NONE;

        if (lockout_active_reg)
        begin
            // Only second ticks act during a lockout: count down and show it.
            if (evt.kind == KIND_SECOND)
            begin
                lockout_left_next = left_dec;
                digits_next[3]    = left_bcd[11:8];
                digits_next[4]    = left_bcd[7:4];
                digits_next[5]    = left_bcd[3:0];
                if (left_dec == 8'd0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        digits_next[i] = BLANK_DIGIT;
                    end
                    lamp_level_next     = 1'b1;
                    lockout_active_next = 1'b0;
                    event_code          = EV_WRONG_CODE;
                end
            end
        end
        else
        begin
            case (evt.kind)
                KIND_KEY:
                begin
                    idle_scans_next = 10'd0;
                    if (!display_active_reg && door_mode_reg == DOOR_CLOSED)
                    begin
                        // First key on a dark, closed lock only wakes the display.
                        display_active_next = 1'b1;
                    end
                    else if (evt.key_index < KEY_DELETE)
                    begin
                        if (entry_count_reg < CNT_W'(CODE_DIGITS))
                        begin
                            digits_next[put_idx] = evt.key_index;
                            entry_count_next     = entry_count_reg + CNT_W'(1);
                        end
                    end
                    else if (evt.key_index == KEY_DELETE)
                    begin
                        if (entry_count_reg != CNT_W'(0))
                        begin
                            entry_count_next     = entry_count_reg - CNT_W'(1);
                            digits_next[del_idx] = BLANK_DIGIT;
                        end
                    end
                    else if (evt.key_index == KEY_CLEAR)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            digits_next[i] = BLANK_DIGIT;
                        end
                        entry_count_next = CNT_W'(0);
                    end
                    else if (evt.key_index == KEY_CONFIRM)
                    begin
                        if (code_match)
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                digits_next[i] = 4'd1;
                            end
                            entry_count_next   = CNT_W'(1);
                            fail_count_next    = 2'd0;
                            lockout_level_next = 7'd0;
                            door_mode_next     = DOOR_OPEN;
                            event_code         = EV_UNLOCKED;
                        end
                        else
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                digits_next[i] = BLANK_DIGIT;
                            end
                            entry_count_next = CNT_W'(0);
                            fail_count_next  = fail_inc;
                            // The two-bit count wrapping to zero also starts a lockout.
                            if (fail_inc >= tries_eff || fail_inc == 2'd0)
                            begin
                                lockout_level_next  = level_inc;
                                lockout_left_next   = left_product[7:0];
                                fail_count_next     = 2'd0;
                                lockout_active_next = 1'b1;
                            end
                        end
                    end
                    else if (evt.key_index == KEY_CLOSE)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            digits_next[i] = BLANK_DIGIT;
                        end
                        entry_count_next = CNT_W'(0);
                        door_mode_next   = DOOR_CLOSED;
                        lamp_level_next  = 1'b1;
                        event_code       = EV_CLOSED;
                    end
                end
                KIND_SCAN:
                begin
                    if (door_mode_reg == DOOR_CLOSED)
                    begin
                        idle_scans_next = scans_inc;
                        if (scans_inc >= idle_timeout_reg)
                        begin
                            idle_scans_next     = 10'd0;
                            display_active_next = 1'b0;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                digits_next[i] = BLANK_DIGIT;
                            end
                            entry_count_next = CNT_W'(0);
                        end
                    end
                end
                KIND_SECOND:
                begin
                    if (door_mode_reg == DOOR_OPEN)
                    begin
                        open_seconds_next = seconds_inc;
                        if (seconds_inc >= open_timeout_reg)
                        begin
                            door_mode_next = DOOR_ALARM;
                            event_code     = EV_LEFT_OPEN;
                        end
                    end
                    else
                    begin
                        open_seconds_next = 8'd0;
                    end
                    // The lamp blinks on every tick in alarm, the raising tick included.
                    if (door_mode_next == DOOR_ALARM)
                    begin
                        lamp_level_next = !lamp_level_reg;
                    end
                end
                default:
                begin
                    // Remote unlock: wake if closed, then unlock as a correct code.
                    if (!display_active_reg && door_mode_reg == DOOR_CLOSED)
                    begin
                        display_active_next = 1'b1;
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        digits_next[i] = 4'd1;
                    end
                    entry_count_next   = CNT_W'(1);
                    fail_count_next    = 2'd0;
                    lockout_level_next = 7'd0;
                    door_mode_next     = DOOR_OPEN;
                    event_code         = EV_UNLOCKED;
                end
            endcase
        end
    end

    // Result word built from the next state.
    always_comb
    begin
        stat_next.door_state    = door_mode_next;
        stat_next.display_on    = display_active_next;
        stat_next.entered_count = 3'(entry_count_next);
        stat_next.digit_one     = digits_next[0];
        stat_next.digit_two     = digits_next[1];
        stat_next.digit_three   = digits_next[2];
        stat_next.digit_four    = digits_next[3];
        stat_next.digit_five    = digits_next[4];
        stat_next.digit_six     = digits_next[5];
        stat_next.lamp          = lamp_level_next;
        stat_next.locked_out    = lockout_active_next;
        stat_next.event_res     = event_code;
    end

    assign stat_valid_next = accept || (stat_valid_reg && !stat_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_mode_reg      <= DOOR_CLOSED;
            display_active_reg <= 1'b0;
            entry_count_reg    <= CNT_W'(0);
            for (int i = 0; i < SLOTS; i++)
            begin
                digits_reg[i] <= BLANK_DIGIT;
            end
            fail_count_reg     <= 2'd0;
            lockout_level_reg  <= 7'd0;
            lockout_left_reg   <= 8'd0;
            lockout_active_reg <= 1'b0;
            open_seconds_reg   <= 8'd0;
            idle_scans_reg     <= 10'd0;
            lamp_level_reg     <= 1'b1;
            stat_valid_reg     <= 1'b0;
        end
        else
        begin
            stat_valid_reg <= stat_valid_next;
            if (accept)
            begin
                door_mode_reg      <= door_mode_next;
                display_active_reg <= display_active_next;
                entry_count_reg    <= entry_count_next;
                digits_reg         <= digits_next;
                fail_count_reg     <= fail_count_next;
                lockout_level_reg  <= lockout_level_next;
                lockout_left_reg   <= lockout_left_next;
                lockout_active_reg <= lockout_active_next;
                open_seconds_reg   <= open_seconds_next;
                idle_scans_reg     <= idle_scans_next;
                lamp_level_reg     <= lamp_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stat_reg <= stat_next;
        end
    end

    // Checks on the lock's own bookkeeping.
    `KLC_ASSERT_NOW(a_level_saturates, 1'b1, lockout_level_reg <= LEVEL_MAX, "lockout level above limit")
    `KLC_ASSERT_NOW(a_count_in_range, 1'b1, entry_count_reg <= CNT_W'(CODE_DIGITS), "entry count beyond code length")
    `KLC_ASSERT_NOW(a_lockout_left_live, lockout_active_reg, lockout_left_reg != 8'd0, "active lockout with zero seconds left")
    `KLC_ASSERT_NEXT(a_lockout_ignores, accept && lockout_active_reg && evt.kind != KIND_SECOND, stat.event_res == EV_NONE && $stable(entry_count_reg) && lockout_active_reg, "word acted on during lockout")
    `KLC_ASSERT_NOW(a_unlock_opens, stat_valid && stat.event_res == EV_UNLOCKED, stat.door_state == DOOR_OPEN, "unlock result without open door")

endmodule

// ----- tb/tb_keypad_lock_controller.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for keypad_lock_controller: event words in, status words out.
// Depends on klc_pkg and the RTL top level; it has its own model of the lock.
// A directed table runs first, then random phases under several register settings.
module tb_keypad_lock_controller;

    import klc_pkg::*;

    localparam int CODE_LEN      = 6;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_WORDS   = 315;
    localparam int HOLD_AT       = 900;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DIRECTED_ROWS = 25;

    // Status words that can be read straight off the lock's rules.
    localparam stat_word_t W_WOKEN = '{DOOR_CLOSED, 1'b1, 3'd0, BLANK_DIGIT, BLANK_DIGIT,
        BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, 1'b1, 1'b0, EV_NONE};
    localparam stat_word_t W_OPENED = '{DOOR_OPEN, 1'b1, 3'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 1'b1, 1'b0, EV_UNLOCKED};
    localparam stat_word_t W_CLOSED = '{DOOR_CLOSED, 1'b1, 3'd0, BLANK_DIGIT, BLANK_DIGIT,
        BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, 1'b1, 1'b0, EV_CLOSED};
    localparam stat_word_t W_LOCKED = '{DOOR_CLOSED, 1'b1, 3'd0, BLANK_DIGIT, BLANK_DIGIT,
        BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, 1'b1, 1'b1, EV_NONE};
    localparam stat_word_t W_LOCK_END = '{DOOR_CLOSED, 1'b1, 3'd0, BLANK_DIGIT, BLANK_DIGIT,
        BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, 1'b1, 1'b0, EV_WRONG_CODE};
    localparam stat_word_t PREDICTED = '0;

    typedef struct packed {
        evt_word_t  word;
        logic       fixed;
        stat_word_t want;
    } row_t;

    typedef struct packed {
        logic [23:0] code;
        logic [7:0]  open_s;
        logic [9:0]  idle_s;
        logic [1:0]  tries;
    } lock_cfg_t;

    // Directed table under the reset settings (code 123456, three tries).
    // A fixed row carries its own expected word; the rest rely on the model below.
    row_t directed [DIRECTED_ROWS] = '{
        '{'{KIND_KEY, 4'd15},        1'b1, W_WOKEN},    // first key only wakes the display
        '{'{KIND_KEY, 4'd1},         1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd2},         1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd3},         1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd4},         1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd5},         1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd6},         1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd0},         1'b0, PREDICTED},  // entry full, digit dropped
        '{'{KIND_KEY, KEY_DELETE},   1'b0, PREDICTED},
        '{'{KIND_KEY, 4'd6},         1'b0, PREDICTED},
        '{'{KIND_KEY, KEY_CONFIRM},  1'b1, W_OPENED},   // correct code opens the door
        '{'{KIND_SECOND, 4'd9},      1'b0, PREDICTED},
        '{'{KIND_KEY, KEY_CLOSE},    1'b1, W_CLOSED},
        '{'{KIND_KEY, KEY_CLEAR},    1'b0, PREDICTED},
        '{'{KIND_KEY, KEY_DELETE},   1'b0, PREDICTED},  // delete on an empty entry
        '{'{KIND_KEY, KEY_CONFIRM},  1'b0, PREDICTED},  // short entry counts as wrong
        '{'{KIND_KEY, KEY_CONFIRM},  1'b0, PREDICTED},
        '{'{KIND_KEY, KEY_CONFIRM},  1'b1, W_LOCKED},   // third failure starts lockout
        '{'{KIND_KEY, 4'd7},         1'b0, PREDICTED},  // ignored while locked out
        '{'{KIND_REMOTE, 4'd3},      1'b0, PREDICTED},  // ignored while locked out
        '{'{KIND_SECOND, 4'd0},      1'b0, PREDICTED},
        '{'{KIND_SECOND, 4'd15},     1'b0, PREDICTED},
        '{'{KIND_SECOND, 4'd8},      1'b0, PREDICTED},
        '{'{KIND_SECOND, 4'd0},      1'b1, W_LOCK_END}, // countdown ends with the wrong-code event
        '{'{KIND_REMOTE, 4'd12},     1'b0, PREDICTED}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        evt_valid;
    logic        evt_ready;
    evt_word_t   evt;
    logic        stat_valid;
    logic        stat_ready;
    stat_word_t  stat;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Model of the lock: register copies and internal state.
    logic [23:0] cfg_code;
    logic [7:0]  cfg_open;
    logic [9:0]  cfg_idle;
    logic [1:0]  cfg_tries;
    logic [1:0]  door_mode;
    logic        disp_on;
    logic [2:0]  entry_cnt;
    digit_t      shown [CODE_LEN];
    logic [1:0]  fail_cnt;
    logic [6:0]  lock_level;
    logic [7:0]  lock_left;
    logic        lock_run;
    logic [7:0]  open_secs;
    logic [9:0]  idle_cnt;
    logic        lamp_lvl;

    stat_word_t  expected_status_q [$];
    evt_word_t   pending_evts [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          counted_words = 0;
    int          cycle_cnt = 0;
    bit          send_steady = 0;
    bit          take_steady = 0;

    keypad_lock_controller i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .stat_valid (stat_valid),
        .stat_ready (stat_ready),
        .stat       (stat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lock model
    // ------------------------------------------------------------------

    function automatic void clear_entry();
        for (int i = 0; i < CODE_LEN; i++)
        begin
            shown[i] = BLANK_DIGIT;
        end
        entry_cnt = 3'd0;
    endfunction

    function automatic void lock_reset();
        cfg_code   = 24'h123456;
        cfg_open   = 8'd20;
        cfg_idle   = 10'd150;
        cfg_tries  = 2'd3;
        door_mode  = DOOR_CLOSED;
        disp_on    = 1'b0;
        clear_entry();
        fail_cnt   = 2'd0;
        lock_level = 7'd0;
        lock_left  = 8'd0;
        lock_run   = 1'b0;
        open_secs  = 8'd0;
        idle_cnt   = 10'd0;
        lamp_lvl   = 1'b1;
    endfunction

    // Unlocking shows 1 in every slot and leaves one digit counted.
    function automatic logic [2:0] open_door();
        for (int i = 0; i < CODE_LEN; i++)
        begin
            shown[i] = 4'd1;
        end
        entry_cnt  = 3'd1;
        fail_cnt   = 2'd0;
        lock_level = 7'd0;
        door_mode  = DOOR_OPEN;
        return EV_UNLOCKED;
    endfunction

    function automatic logic [2:0] confirm_entry();
        logic       match;
        logic [1:0] tries;
        match = (entry_cnt >= CODE_LEN);
        tries = (cfg_tries == 2'd0) ? 2'd1 : cfg_tries;
        for (int i = 0; i < CODE_LEN; i++)
        begin
            if (shown[i] != cfg_code[4 * (CODE_LEN - 1 - i) +: 4])
            begin
                match = 1'b0;
            end
        end
        if (match)
        begin
            return open_door();
        end
        clear_entry();
        fail_cnt = fail_cnt + 2'd1;
        // The failure counter wraps at four; a wrap also starts a lockout.
        if (fail_cnt >= tries || fail_cnt == 2'd0)
        begin
            if (lock_level < LEVEL_MAX)
            begin
                lock_level = lock_level + 7'd1;
            end
            lock_left = 8'(int'(tries) * int'(lock_level) + 1);
            fail_cnt  = 2'd0;
            lock_run  = 1'b1;
        end
        return EV_NONE;
    endfunction

    // Advances the model by one event word and returns the status word it yields.
    function automatic stat_word_t predict_status(input evt_word_t w);
        stat_word_t s;
        logic [2:0] ev;
        ev = EV_NONE;
        if (lock_run)
        begin
            // Only second ticks matter during a lockout; they run the countdown.
            if (w.kind == KIND_SECOND)
            begin
                if (lock_left != 8'd0)
                begin
                    lock_left = lock_left - 8'd1;
                end
                shown[3] = digit_t'(lock_left / 8'd100);
                shown[4] = digit_t'((lock_left % 8'd100) / 8'd10);
                shown[5] = digit_t'(lock_left % 8'd10);
                if (lock_left == 8'd0)
                begin
                    for (int i = 0; i < CODE_LEN; i++)
                    begin
                        shown[i] = BLANK_DIGIT;
                    end
                    lamp_lvl = 1'b1;
                    lock_run = 1'b0;
                    ev       = EV_WRONG_CODE;
                end
            end
        end
        else if (w.kind == KIND_KEY)
        begin
            if (!disp_on && door_mode == DOOR_CLOSED)
            begin
                disp_on = 1'b1;
            end
            else if (w.key_index < KEY_DELETE)
            begin
                if (entry_cnt < CODE_LEN)
                begin
                    shown[entry_cnt] = w.key_index;
                    entry_cnt        = entry_cnt + 3'd1;
                end
            end
            else if (w.key_index == KEY_DELETE)
            begin
                if (entry_cnt != 3'd0)
                begin
                    entry_cnt        = entry_cnt - 3'd1;
                    shown[entry_cnt] = BLANK_DIGIT;
                end
            end
            else if (w.key_index == KEY_CLEAR)
            begin
                clear_entry();
            end
            else if (w.key_index == KEY_CONFIRM)
            begin
                ev = confirm_entry();
            end
            else if (w.key_index == KEY_CLOSE)
            begin
                clear_entry();
                door_mode = DOOR_CLOSED;
                lamp_lvl  = 1'b1;
                ev        = EV_CLOSED;
            end
            idle_cnt = 10'd0;
        end
        else if (w.kind == KIND_SCAN)
        begin
            if (door_mode == DOOR_CLOSED)
            begin
                if (idle_cnt < IDLE_SCAN_MAX)
                begin
                    idle_cnt = idle_cnt + 10'd1;
                end
                if (idle_cnt >= cfg_idle)
                begin
                    idle_cnt = 10'd0;
                    disp_on  = 1'b0;
                    clear_entry();
                end
            end
        end
        else if (w.kind == KIND_SECOND)
        begin
            if (door_mode == DOOR_OPEN)
            begin
                if (open_secs < OPEN_SEC_MAX)
                begin
                    open_secs = open_secs + 8'd1;
                end
                if (open_secs >= cfg_open)
                begin
                    door_mode = DOOR_ALARM;
                    ev        = EV_LEFT_OPEN;
                end
            end
            else
            begin
                open_secs = 8'd0;
            end
            // The lamp blinks in the alarm state, starting on the tick that raised it.
            if (door_mode == DOOR_ALARM)
            begin
                lamp_lvl = ~lamp_lvl;
            end
        end
        else
        begin
            if (!disp_on && door_mode == DOOR_CLOSED)
            begin
                disp_on = 1'b1;
            end
            ev = open_door();
        end
        s.door_state    = door_mode;
        s.display_on    = disp_on;
        s.entered_count = entry_cnt;
        s.digit_one     = shown[0];
        s.digit_two     = shown[1];
        s.digit_three   = shown[2];
        s.digit_four    = shown[3];
        s.digit_five    = shown[4];
        s.digit_six     = shown[5];
        s.lamp          = lamp_lvl;
        s.locked_out    = lock_run;
        s.event_res     = ev;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic evt_word_t mk_evt(input logic [1:0] kind, input logic [3:0] key);
        evt_word_t w;
        w.kind      = kind;
        w.key_index = key;
        return w;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] rand_bcd_code();
        logic [23:0] c;
        for (int i = 0; i < CODE_LEN; i++)
        begin
            c[4 * i +: 4] = 4'($urandom_range(0, 9));
        end
        return c;
    endfunction

    // Queues up the next short sequence. The largest share are code entries that reach the
    // confirm logic; the rest are tick bursts, scan bursts, closes, remote unlocks and noise.
    // While locked out, the sequence is mostly second ticks to end the countdown.
    function automatic void plan_sequence();
        int          pick;
        int          n;
        logic [3:0]  d;
        if (lock_run)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                pending_evts.push_back(mk_evt(KIND_SECOND, 4'($urandom)));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                pending_evts.push_back(mk_evt(2'($urandom), 4'($urandom)));
            end
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if (!disp_on && door_mode == DOOR_CLOSED)
            begin
                pending_evts.push_back(mk_evt(KIND_KEY, 4'($urandom)));
            end
            for (int i = 0; i < CODE_LEN; i++)
            begin
                d = cfg_code[4 * (CODE_LEN - 1 - i) +: 4];
                if ($urandom_range(0, 11) == 0)
                begin
                    d = 4'($urandom_range(0, 9));
                end
                pending_evts.push_back(mk_evt(KIND_KEY, d));
                if ($urandom_range(0, 9) == 0)
                begin
                    pending_evts.push_back(mk_evt(KIND_KEY, KEY_DELETE));
                    pending_evts.push_back(mk_evt(KIND_KEY, d));
                end
            end
            pending_evts.push_back(mk_evt(KIND_KEY, KEY_CONFIRM));
        end
        else if (pick < 60)
        begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
            begin
                pending_evts.push_back(mk_evt(KIND_SECOND, 4'($urandom)));
            end
        end
        else if (pick < 72)
        begin
            n = $urandom_range(1, 12);
            if ($urandom_range(0, 19) == 0)
            begin
                n = (int'(cfg_idle) + 1 < 40) ? int'(cfg_idle) + 1 : 40;
            end
            for (int i = 0; i < n; i++)
            begin
                pending_evts.push_back(mk_evt(KIND_SCAN, 4'($urandom)));
            end
        end
        else if (pick < 82)
        begin
            pending_evts.push_back(mk_evt(KIND_KEY, KEY_CLOSE));
        end
        else if (pick < 88)
        begin
            pending_evts.push_back(mk_evt(KIND_REMOTE, 4'($urandom)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                pending_evts.push_back(mk_evt(2'($urandom), 4'($urandom)));
            end
        end
    endfunction

    // Offers one event word and waits for it to be taken. On acceptance the model
    // steps and the expected status word is queued: the fixed one for a fixed row,
    // otherwise the model's own. Words the lockout ignores are not counted.
    task automatic drive_word(input evt_word_t w, input logic fixed, input stat_word_t want);
        int         gap;
        stat_word_t predicted;
        logic       ignored;
        gap = send_steady ? 0 : pick_gap();
        if ($urandom_range(0, 49) == 0)
        begin
            send_steady = !send_steady;
        end
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= w;
        do
        begin
            @(posedge clk);
        end
        while (!evt_ready);
        ignored   = lock_run && (w.kind != KIND_SECOND);
        predicted = predict_status(w);
        expected_status_q.push_back(fixed ? want : predicted);
        if (!ignored)
        begin
            counted_words++;
        end
    endtask

    // Drops valid and waits until every expected status word has come back.
    task automatic drain();
        evt_valid <= 1'b0;
        while (expected_status_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes one register (setup then access phase), reads it back, and mirrors
    // the value into the model's copy, leaving the bus idle afterwards.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("register %0d readback: expected %0h, got %0h", idx, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PASS_CODE:    cfg_code  = value[23:0];
            REG_OPEN_TIMEOUT: cfg_open  = value[7:0];
            REG_IDLE_TIMEOUT: cfg_idle  = value[9:0];
            default:          cfg_tries = value[1:0];
        endcase
        @(posedge clk);
    endtask

    function automatic lock_cfg_t phase_settings(input int phase);
        lock_cfg_t c;
        case (phase)
            0: c = '{24'h000000, 8'd1, 10'd1, 2'd1};
            1: c = '{24'hFFFFFF, 8'd255, 10'd1023, 2'd3};
            2: c = '{rand_bcd_code(), 8'd3, 10'd7, 2'd2};
            3: c = '{rand_bcd_code(), 8'($urandom_range(2, 12)), 10'($urandom_range(2, 20)),
                     2'($urandom_range(1, 3))};
            default: c = '{24'h999999, 8'd2, 10'd2, 2'd3};
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Each status word taken is compared against the oldest expectation.
    always @(posedge clk)
    begin
        stat_word_t want;
        if (rst_n && stat_valid && stat_ready)
        begin
            results_seen++;
            if (expected_status_q.size() == 0)
            begin
                $error("status word with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = expected_status_q.pop_front();
                check_field("door_state", 8'(want.door_state), 8'(stat.door_state));
                check_field("display_on", 8'(want.display_on), 8'(stat.display_on));
                check_field("entered_count", 8'(want.entered_count), 8'(stat.entered_count));
                check_field("digit_one", 8'(want.digit_one), 8'(stat.digit_one));
                check_field("digit_two", 8'(want.digit_two), 8'(stat.digit_two));
                check_field("digit_three", 8'(want.digit_three), 8'(stat.digit_three));
                check_field("digit_four", 8'(want.digit_four), 8'(stat.digit_four));
                check_field("digit_five", 8'(want.digit_five), 8'(stat.digit_five));
                check_field("digit_six", 8'(want.digit_six), 8'(stat.digit_six));
                check_field("lamp", 8'(want.lamp), 8'(stat.lamp));
                check_field("locked_out", 8'(want.locked_out), 8'(stat.locked_out));
                check_field("event_res", 8'(want.event_res), 8'(stat.event_res));
            end
        end
    end

    // Receiver: random stalls, stretches with none, and one long hold-off while
    // the sender keeps offering, so the result register fills and evt_ready drops.
    initial
    begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 0;
        stat_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_seen >= HOLD_AT && !hold_done)
            begin
                hold_done  = 1;
                stat_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stat_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stat_ready <= 1'b1;
                if (!take_steady && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
                if ($urandom_range(0, 49) == 0)
                begin
                    take_steady = !take_steady;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        lock_cfg_t cfg;
        rst_n     = 1'b0;
        evt_valid = 1'b0;
        evt       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        lock_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            drive_word(directed[i].word, directed[i].fixed, directed[i].want);
        end
        drain();

        // Random phases, each under its own register settings, written while idle.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            cfg = phase_settings(phase);
            write_reg(REG_PASS_CODE, {8'd0, cfg.code});
            write_reg(REG_OPEN_TIMEOUT, {24'd0, cfg.open_s});
            write_reg(REG_IDLE_TIMEOUT, {22'd0, cfg.idle_s});
            write_reg(REG_TRIES, {30'd0, cfg.tries});
            counted_words = 0;
            pending_evts.delete();
            while (counted_words < PHASE_WORDS)
            begin
                if (pending_evts.size() == 0)
                begin
                    plan_sequence();
                end
                drive_word(pending_evts.pop_front(), 1'b0, PREDICTED);
            end
            drain();
        end

        // The block answers in the cycle after taking a word; idle before the verdict.
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
